// ===== sv/ebl_pkg.sv =====
// Package for the exit button lock controller.
// Holds the shared codes, widths, configuration and result types.
// No dependencies.
package ebl_pkg;

  localparam int CountW = 16;
  localparam int IndexW = 3;
  localparam int DataW  = 16;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_TEST   = 2'd2;

  localparam logic [1:0] MODE_MOMENTARY = 2'd0;
  localparam logic [1:0] MODE_TOGGLE    = 2'd1;
  localparam logic [1:0] MODE_LATCH     = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_DISARM = 2'd1;
  localparam logic [1:0] ACT_ARM    = 2'd2;

  localparam logic [1:0] LINE_BOTH = 2'd0;
  localparam logic [1:0] LINE_ONE  = 2'd1;
  localparam logic [1:0] LINE_TWO  = 2'd2;

  localparam logic [1:0] LOCKS_BOTH = 2'd3;
  localparam logic [1:0] ROUTE_NONE = 2'd0;

  localparam logic [IndexW-1:0] REG_ENABLE = 3'd0;
  localparam logic [IndexW-1:0] REG_MODE   = 3'd1;
  localparam logic [IndexW-1:0] REG_SELECT = 3'd2;
  localparam logic [IndexW-1:0] REG_DELAY  = 3'd3;
  localparam logic [IndexW-1:0] REG_ROUTE  = 3'd4;

  typedef struct packed {
    logic              button_enable;
    logic [1:0]        button_mode;
    logic [1:0]        lock_select;
    logic [CountW-1:0] rearm_delay;
    logic [1:0]        alert_route;
  } cfg_t;

  typedef struct packed {
    logic [1:0] lock_action;
    logic [1:0] lock_bits;
    logic       alert_fire;
    logic [1:0] alert_line;
    logic [1:0] alert_code;
    logic       button_pressed;
    logic       toggle_armed;
  } result_t;

endpackage

// ===== sv/ebl_cfg.sv =====
// Configuration registers of the exit button lock controller.
// Depends on ebl_pkg for the register indexes and the cfg_t type.
module ebl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ebl_pkg::IndexW-1:0]  cfg_index,
  input  logic [ebl_pkg::DataW-1:0]   cfg_wdata,
  output ebl_pkg::cfg_t               cfg,
  output logic                        clear_toggle
);

  ebl_pkg::cfg_t regs;

  assign cfg = regs;
  assign clear_toggle = cfg_we && (cfg_index == ebl_pkg::REG_MODE) &&
                        (cfg_wdata[1:0] != ebl_pkg::MODE_TOGGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.button_enable <= 1'b0;
      regs.button_mode   <= ebl_pkg::MODE_MOMENTARY;
      regs.lock_select   <= 2'd1;
      regs.rearm_delay   <= ebl_pkg::CountW'(4);
      regs.alert_route   <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        ebl_pkg::REG_ENABLE: regs.button_enable <= cfg_wdata[0];
        ebl_pkg::REG_MODE:   regs.button_mode   <= cfg_wdata[1:0];
        ebl_pkg::REG_SELECT: begin
          if (cfg_wdata[1:0] != 2'd0) regs.lock_select <= cfg_wdata[1:0];
        end
        ebl_pkg::REG_DELAY:  regs.rearm_delay   <= cfg_wdata[ebl_pkg::CountW-1:0];
        ebl_pkg::REG_ROUTE:  regs.alert_route   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ebl_step.sv =====
// Per-item update: button state, re-arm timer and lock/alert decision.
// Depends on ebl_pkg for codes and the cfg_t and result_t types.
module ebl_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       command,
  input  logic             pin_level,
  input  ebl_pkg::cfg_t    cfg,
  input  logic             clear_toggle,
  output ebl_pkg::result_t res
);

  logic                       last_pressed, last_pressed_next;
  logic                       toggle_flag, toggle_flag_next;
  logic [ebl_pkg::CountW-1:0] second_count, second_count_next;
  logic                       timer_done, timer_done_next;

  logic pressed;
  logic drive, arm, with_alert, fire;

  assign pressed = ~pin_level;

  always_comb begin
    last_pressed_next = last_pressed;
    toggle_flag_next  = toggle_flag;
    second_count_next = second_count;
    timer_done_next   = timer_done;
    drive      = 1'b0;
    arm        = 1'b0;
    with_alert = 1'b0;
    case (command)
      ebl_pkg::CMD_SAMPLE: begin
        if (cfg.button_enable) begin
          if (cfg.button_mode == ebl_pkg::MODE_LATCH) begin
            if (pressed != last_pressed) begin
              drive           = 1'b1;
              arm             = pressed;
              with_alert      = 1'b1;
              timer_done_next = 1'b1;
            end
          end else if (pressed && !last_pressed) begin
            drive      = 1'b1;
            with_alert = 1'b1;
            if (cfg.button_mode == ebl_pkg::MODE_TOGGLE) begin
              toggle_flag_next = ~toggle_flag;
              arm              = ~toggle_flag;
              timer_done_next  = 1'b1;
            end else begin
              timer_done_next   = 1'b0;
              second_count_next = '0;
            end
          end
        end
        last_pressed_next = pressed;
      end
      ebl_pkg::CMD_TICK: begin
        if (second_count >= cfg.rearm_delay && !timer_done) begin
          drive           = 1'b1;
          arm             = 1'b1;
          timer_done_next = 1'b1;
        end else if (second_count != ebl_pkg::COUNT_MAX) begin
          second_count_next = second_count + 1'b1;
        end
      end
      ebl_pkg::CMD_TEST: begin
        drive      = 1'b1;
        with_alert = 1'b1;
        if (cfg.button_mode == ebl_pkg::MODE_LATCH) begin
          arm             = 1'b1;
          timer_done_next = 1'b1;
        end else if (cfg.button_mode == ebl_pkg::MODE_TOGGLE) begin
          toggle_flag_next = ~toggle_flag;
          arm              = ~toggle_flag;
          timer_done_next  = 1'b1;
        end else begin
          timer_done_next   = 1'b0;
          second_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  assign fire = drive && with_alert && (cfg.alert_route != ebl_pkg::ROUTE_NONE);

  always_comb begin
    res.lock_action = !drive ? ebl_pkg::ACT_NONE :
                      (arm ? ebl_pkg::ACT_ARM : ebl_pkg::ACT_DISARM);
    res.lock_bits   = drive ? cfg.lock_select : 2'd0;
    res.alert_fire  = fire;
    res.alert_code  = fire ? cfg.alert_route : 2'd0;
    if (!fire) begin
      res.alert_line = ebl_pkg::LINE_BOTH;
    end else if (cfg.lock_select == ebl_pkg::LOCKS_BOTH) begin
      res.alert_line = ebl_pkg::LINE_BOTH;
    end else if (cfg.lock_select[0]) begin
      res.alert_line = ebl_pkg::LINE_ONE;
    end else begin
      res.alert_line = ebl_pkg::LINE_TWO;
    end
    res.button_pressed = last_pressed_next;
    res.toggle_armed   = toggle_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed <= 1'b0;
      toggle_flag  <= 1'b0;
      second_count <= '0;
      timer_done   <= 1'b0;
    end else begin
      if (accept) begin
        last_pressed <= last_pressed_next;
        second_count <= second_count_next;
        timer_done   <= timer_done_next;
      end
      if (clear_toggle) begin
        toggle_flag <= 1'b0;
      end else if (accept) begin
        toggle_flag <= toggle_flag_next;
      end
    end
  end

  a_fire_needs_action: assert property (@(posedge clk) disable iff (rst)
    res.alert_fire |-> res.lock_action != ebl_pkg::ACT_NONE)
    else $error("alert raised without a lock action");

  a_tick_rearm: assert property (@(posedge clk) disable iff (rst)
    (accept && command == ebl_pkg::CMD_TICK && !timer_done &&
     second_count >= cfg.rearm_delay) |=> timer_done)
    else $error("expired tick did not mark the timer done");

  a_sample_records: assert property (@(posedge clk) disable iff (rst)
    (accept && command == ebl_pkg::CMD_SAMPLE) |=> last_pressed == !$past(pin_level))
    else $error("sample did not record the pressed status");

  a_momentary_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && res.lock_action == ebl_pkg::ACT_DISARM &&
     cfg.button_mode != ebl_pkg::MODE_TOGGLE && cfg.button_mode != ebl_pkg::MODE_LATCH)
    |=> second_count == '0 && !timer_done)
    else $error("momentary disarm did not restart the re-arm timer");

endmodule

// ===== sv/ebl_obuf.sv =====
// Two-entry result buffer between the update logic and the output channel.
// Depends on ebl_pkg for the result_t type.
module ebl_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ebl_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output ebl_pkg::result_t out_data
);

  ebl_pkg::result_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");

  a_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

// ===== sv/exit_button_lock_controller_core.sv =====
// Exit button lock controller, top level.
// Input channel: in_valid/in_stall carry command (0 pin sample, 1 one-second
// tick, 2 test) and pin_level (active low). Output channel: out_valid/out_stall
// carry one result per input: lock_action, lock_bits, alert fields and the
// button and toggle status after the item.
// A transfer happens at a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 enable,
// 1 mode, 2 lock select, 3 re-arm delay, 4 alert route); no read-back.
// A result enters the buffer at its input transfer and is valid in the next
// cycle when no older result is waiting in the buffer.
// Throughput: one item per cycle while in_stall is low; the update is a
// single pass of logic from the input ports and state registers into a
// two-entry result buffer. in_stall is high while both buffer entries hold
// results the receiver has not yet taken; with inputs streaming, each
// stalled output cycle raises in_stall in the cycle after it.
// Reset (rst, synchronous): registers return to their defaults, button and
// timer state clear, and the result buffer empties.
// Depends on ebl_pkg, ebl_cfg, ebl_step and ebl_obuf.
module exit_button_lock_controller_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ebl_pkg::IndexW-1:0] cfg_index,
  input  logic [ebl_pkg::DataW-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 command,
  input  logic                       pin_level,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 lock_action,
  output logic [1:0]                 lock_bits,
  output logic                       alert_fire,
  output logic [1:0]                 alert_line,
  output logic [1:0]                 alert_code,
  output logic                       button_pressed,
  output logic                       toggle_armed
);

  ebl_pkg::cfg_t    cfg;
  ebl_pkg::result_t step_res;
  ebl_pkg::result_t out_res;
  logic             clear_toggle;
  logic             full;
  logic             accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ebl_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cfg          (cfg),
    .clear_toggle (clear_toggle)
  );

  ebl_step u_step (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .pin_level    (pin_level),
    .cfg          (cfg),
    .clear_toggle (clear_toggle),
    .res          (step_res)
  );

  ebl_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign lock_action    = out_res.lock_action;
  assign lock_bits      = out_res.lock_bits;
  assign alert_fire     = out_res.alert_fire;
  assign alert_line     = out_res.alert_line;
  assign alert_code     = out_res.alert_code;
  assign button_pressed = out_res.button_pressed;
  assign toggle_armed   = out_res.toggle_armed;

endmodule
